// ===== rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// shared widths, register indexes, reset values and types for the detector
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int CFG_WIDTH   = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int TDATA_W     = 8;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  localparam cfg_idx_t REG_MISS_TIMEOUT = 1'd0;
  localparam cfg_idx_t REG_SETTLE       = 1'd1;

  localparam cfg_word_t MISS_TIMEOUT_RST = 24'd10000;
  localparam cfg_word_t SETTLE_RST       = 24'd500000;

  typedef struct packed {
    cfg_word_t miss_timeout;
    cfg_word_t settle;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic path_open;
  } result_t;

  // saturating increment
  function automatic count_t count_up(input count_t v);
    count_t r;
    r = (&v) ? v : count_t'(v + 1'b1);
    return r;
  endfunction

endpackage

// ===== rtl/mpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mpd_cfg_regs
// timeout and settle registers with a plain write port
// ----------------------------------------------------------------------------
module mpd_cfg_regs
  import mpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_addr,
  input  cfg_word_t cfg_wdata,
  output cfg_t      cfg
);

  cfg_word_t miss_timeout_r;
  cfg_word_t settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_timeout_r <= MISS_TIMEOUT_RST;
      settle_r       <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MISS_TIMEOUT: miss_timeout_r <= cfg_wdata;
        REG_SETTLE:       settle_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.miss_timeout = miss_timeout_r;
  assign cfg.settle       = settle_r;

endmodule

// ===== rtl/mpd_core.sv =====
// ----------------------------------------------------------------------------
// mpd_core
// missing-pulse timer, settle timer and path state, one tick per beat
// ----------------------------------------------------------------------------
module mpd_core
  import mpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    tick,
  input  logic    pulse_edge,
  input  cfg_t    cfg,
  output result_t res
);

  logic   path_open_r,     path_open_nxt;
  count_t miss_elapsed_r,  miss_elapsed_nxt;
  logic   miss_armed_r,    miss_armed_nxt;
  count_t settle_elapsed_r, settle_elapsed_nxt;
  logic   settle_armed_r,  settle_armed_nxt;
  logic   first_pending_r, first_pending_nxt;

  always_comb begin
    logic   settle_restart;
    count_t miss_inc;
    count_t settle_inc;
    settle_restart     = 1'b0;
    miss_inc           = count_up(miss_elapsed_r);
    settle_inc         = count_up(settle_elapsed_r);
    path_open_nxt      = path_open_r;
    miss_elapsed_nxt   = miss_elapsed_r;
    miss_armed_nxt     = miss_armed_r;
    settle_elapsed_nxt = settle_elapsed_r;
    settle_armed_nxt   = settle_armed_r;
    first_pending_nxt  = first_pending_r;
    res.valid          = 1'b0;
    res.path_open      = path_open_r;

    if (pulse_edge) begin
      miss_elapsed_nxt = '0;
      miss_armed_nxt   = 1'b1;
      if (!path_open_r) begin
        path_open_nxt  = 1'b1;
        settle_restart = 1'b1;
      end
    end else if (miss_armed_r) begin
      miss_elapsed_nxt = miss_inc;
      if (miss_inc >= count_t'(cfg.miss_timeout)) begin
        miss_armed_nxt = 1'b0;
        path_open_nxt  = 1'b0;
        settle_restart = 1'b1;
      end
    end

    if (settle_restart) begin
      settle_elapsed_nxt = '0;
      settle_armed_nxt   = 1'b1;
    end else if (settle_armed_r) begin
      settle_elapsed_nxt = settle_inc;
      if (settle_inc >= count_t'(cfg.settle)) begin
        settle_armed_nxt  = 1'b0;
        res.valid         = tick && !first_pending_r;
        first_pending_nxt = 1'b0;
      end
    end
    res.path_open = path_open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_open_r      <= 1'b0;
      miss_elapsed_r   <= '0;
      miss_armed_r     <= 1'b1;
      settle_elapsed_r <= '0;
      settle_armed_r   <= 1'b0;
      first_pending_r  <= 1'b1;
    end else if (tick) begin
      path_open_r      <= path_open_nxt;
      miss_elapsed_r   <= miss_elapsed_nxt;
      miss_armed_r     <= miss_armed_nxt;
      settle_elapsed_r <= settle_elapsed_nxt;
      settle_armed_r   <= settle_armed_nxt;
      first_pending_r  <= first_pending_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pulse_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && pulse_edge) |=> (path_open_r && miss_armed_r && miss_elapsed_r == '0))
    else $error("pulse did not open the path and re-arm the miss timer");

  a_report_needs_settle: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (settle_armed_r && !first_pending_r))
    else $error("report without an armed settle timer");

  a_report_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> !settle_armed_r)
    else $error("settle timer still armed after a report");

  a_miss_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && $fell(miss_armed_nxt) && !pulse_edge) |=> !path_open_r)
    else $error("miss timeout did not close the path");
`endif

endmodule

// ===== rtl/mpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// mpd_out_stage
// result register on the output stream, accepts a new beat while draining
// ----------------------------------------------------------------------------
module mpd_out_stage
  import mpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  result_t            res,
  output logic               load_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata
);

  logic out_valid_r, out_valid_nxt;
  logic out_open_r;

  assign load_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_open_r <= res.path_open;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-1){1'b0}}, out_open_r};

endmodule

// ===== rtl/missing_pulse_presence_detector_unit.sv =====
// ----------------------------------------------------------------------------
// missing_pulse_presence_detector_unit
// missing-pulse detector with a settle filter on a tick stream
// ----------------------------------------------------------------------------
// Each input beat is one time tick, in_tdata[0] set when a receiver edge was
// seen. An edge re-arms the miss timer and opens the path; a miss timeout
// closes it; after settle_ticks of a new state the state is reported once on
// the output stream (out_tdata[0], 1 open), the first report after reset is
// dropped. The block holds one register stage for state and one output
// register, so a beat is taken each cycle while the output register is
// empty or being read; a pending result stalls the input only while
// out_tready is low. Write registers only while the block is idle.
module missing_pulse_presence_detector_unit
  import mpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [0] pulse_edge
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [0] path_open_report
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_addr,
  input  cfg_word_t          cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  logic    load_ready;
  logic    tick;

  assign in_tready = load_ready;
  assign tick      = in_tvalid && load_ready;

  mpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mpd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .pulse_edge (in_tdata[0]),
    .cfg        (cfg),
    .res        (res)
  );

  mpd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .load_ready (load_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/missing_pulse_presence_detector_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// missing_pulse_presence_detector_unit_test
// self-checking bench: drives tick beats with and without edges, tracks the
// miss and settle timers in a local predictor and checks every report beat
// ----------------------------------------------------------------------------
module missing_pulse_presence_detector_unit_test;
  import mpd_pkg::*;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;   // [0] pulse_edge
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;         // [0] path_open_report
  logic               cfg_we     = 1'b0;
  cfg_idx_t           cfg_addr   = REG_MISS_TIMEOUT;
  cfg_word_t          cfg_wdata  = '0;

  // predictor copy of the detector
  cfg_word_t miss_limit;
  cfg_word_t settle_limit;
  logic      path_open_q;
  logic      miss_running;
  logic      settle_running;
  logic      first_pending;
  count_t    miss_count;
  count_t    settle_count;
  logic      expected_reports[$];

  int mismatch_count    = 0;
  int ticks_sent        = 0;
  bit idle_en           = 1'b1;
  int stall_left        = 0;

  missing_pulse_presence_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_predictor();
    miss_limit     = MISS_TIMEOUT_RST;
    settle_limit   = SETTLE_RST;
    path_open_q    = 1'b0;
    miss_running   = 1'b1;
    settle_running = 1'b0;
    first_pending  = 1'b1;
    miss_count     = '0;
    settle_count   = '0;
  endfunction

  function automatic void advance_tick(input logic pulse);
    logic settle_restart;
    settle_restart = 1'b0;
    if (pulse) begin
      miss_count   = '0;
      miss_running = 1'b1;
      if (!path_open_q) begin
        path_open_q    = 1'b1;
        settle_restart = 1'b1;
      end
    end else if (miss_running) begin
      if (miss_count != '1) miss_count = miss_count + 1'b1;
      if (miss_count >= miss_limit) begin
        miss_running   = 1'b0;
        path_open_q    = 1'b0;
        settle_restart = 1'b1;
      end
    end
    if (settle_restart) begin
      settle_count   = '0;
      settle_running = 1'b1;
    end else if (settle_running) begin
      if (settle_count != '1) settle_count = settle_count + 1'b1;
      if (settle_count >= settle_limit) begin
        settle_running = 1'b0;
        if (!first_pending) begin
          expected_reports.push_back(path_open_q);
        end
        first_pending = 1'b0;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (idle_en && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 15);
    out_tready <= !(idle_en && stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin : check_reports
    logic want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report beat, path_open_report %b",
                                  out_tdata[0]));
      end else begin
        want = expected_reports.pop_front();
        if (out_tdata[0] !== want)
          report_mismatch($sformatf("path_open_report got %b want %b", out_tdata[0], want));
      end
    end
  end

  task automatic send_tick(input logic pulse);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-1){1'b0}}, pulse};
    do @(posedge clk); while (!in_tready);
    advance_tick(pulse);
    ticks_sent++;
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int i = 0; i < n; i++) send_tick(bits[i]);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_word_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MISS_TIMEOUT) miss_limit = value;
    else settle_limit = value;
  endtask

  task automatic set_timing(input cfg_word_t miss, input cfg_word_t settle);
    write_reg(REG_MISS_TIMEOUT, miss);
    write_reg(REG_SETTLE, settle);
  endtask

  // miss timer at its reset value stays quiet, first report dropped
  task automatic test_default_miss_timeout();
    write_reg(REG_SETTLE, 24'd3);
    idle_en = 1'b0;
    repeat (300) send_tick(1'b0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    idle_en = 1'b1;
    wait_drain();
  endtask

  task automatic test_directed_corners();
    set_timing(24'd1, 24'd1);
    send_pattern(32'b0011_0100_1101, 12);
    wait_drain();
    // zero registers behave as one
    set_timing(24'd0, 24'd0);
    send_pattern(32'b01_0011, 6);
    wait_drain();
    set_timing('1, '1);
    send_pattern(32'b1001, 4);
    wait_drain();
    // settle still running from the max setting, now expires at once
    set_timing(24'd2, 24'd1);
    send_pattern(32'b000, 3);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int start_ticks;
    int phase_end;
    int m;
    int s;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < 1650) begin
      wait_drain();
      if ($urandom_range(0, 9) == 0)
        set_timing(cfg_word_t'($urandom_range(0, 1)), cfg_word_t'($urandom_range(0, 1)));
      else
        set_timing(cfg_word_t'($urandom_range(1, 12)), cfg_word_t'($urandom_range(1, 20)));
      if (ticks_sent - start_ticks > 1400) idle_en = 1'b0;
      m = int'(miss_limit);
      s = int'(settle_limit);
      phase_end = ticks_sent + $urandom_range(80, 160);
      while (ticks_sent < phase_end) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            // edges spaced inside the miss window keep the path open
            repeat ($urandom_range(1, 6)) begin
              send_tick(1'b1);
              repeat ($urandom_range(0, (m > 1) ? m - 2 : 0)) send_tick(1'b0);
            end
          end
          2: repeat ($urandom_range(1, m + s + 3)) send_tick(1'b0);
          default: repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
        endcase
      end
    end
    wait_drain();
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_miss_timeout();
    test_directed_corners();
    test_random_traffic();
    if (expected_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mpd_pkg.sv
rtl/mpd_cfg_regs.sv
rtl/mpd_core.sv
rtl/mpd_out_stage.sv
rtl/missing_pulse_presence_detector_unit.sv
sim/missing_pulse_presence_detector_unit_test.sv
